// File: src/frca_pkg.sv
package frca_pkg;

  // Field and bus widths
  localparam int SizeW     = 32;
  localparam int IndexW    = 4;
  localparam int CapW      = 32;
  localparam int OffsetW   = 32;
  localparam int InDataW   = 32;
  localparam int OutDataW  = 72;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 32;

  // Defaults and fallbacks for the configuration registers
  localparam int MaxChunksDefault = 16;
  localparam logic [31:0] DefMinChunk  = 32'd2097152;
  localparam logic [4:0]  DefAlignLog2 = 5'd8;
  localparam logic [5:0]  DefFrames    = 6'd3;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_MIN_CHUNK  = 2'd0,
    CFG_ALIGN_LOG2 = 2'd1,
    CFG_FRAMES     = 2'd2
  } cfg_index_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // latch the request size
    logic start;    // issue the first table read
    logic advance;  // frame tick, zero result
    logic eval;     // table read data valid, try the bump
    logic step;     // issue the next table read
    logic hit;      // record a successful bump
    logic create;   // record a new chunk
    logic fail;     // table full result
    logic publish;  // move the result to the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic start_ok;  // at least one table entry to try
    logic fit;       // current entry serves the request
    logic more;      // another entry remains to try
    logic full;      // table has no free entry
    logic out_free;  // output register can take a result
  } ctrl_status_t;

endpackage

// File: src/frca_ctrl.sv
module frca_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_advance_i,
  output logic                   in_ready_o,
  input  frca_pkg::ctrl_status_t status_i,
  output frca_pkg::ctrl_cmd_t    cmd_o
);
  import frca_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PROBE  = 4'b0010,
    ST_CREATE = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_advance_i) begin
            cmd_o.advance = 1'b1;
            state_d       = ST_RESULT;
          end else if (status_i.start_ok) begin
            cmd_o.start = 1'b1;
            state_d     = ST_PROBE;
          end else begin
            state_d = ST_CREATE;
          end
        end
      end
      ST_PROBE: begin
        cmd_o.eval = 1'b1;
        if (status_i.fit) begin
          cmd_o.hit = 1'b1;
          state_d   = ST_RESULT;
        end else if (status_i.more) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_CREATE;
        end
      end
      ST_CREATE: begin
        if (status_i.full) begin
          cmd_o.fail = 1'b1;
        end else begin
          cmd_o.create = 1'b1;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/frca_datapath.sv
module frca_datapath #(
  parameter int MaxChunks = frca_pkg::MaxChunksDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [frca_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [frca_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [frca_pkg::SizeW-1:0]     req_size_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           out_status_o,
  output logic [frca_pkg::IndexW-1:0]    out_index_o,
  output logic [frca_pkg::OffsetW-1:0]   out_byte_off_o,
  output logic                           out_created_o,
  output logic [frca_pkg::CapW-1:0]      out_capacity_o,
  input  frca_pkg::ctrl_cmd_t            cmd_i,
  output frca_pkg::ctrl_status_t         status_o
);
  import frca_pkg::*;

  localparam int IdxW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int CntW = $clog2(MaxChunks + 1);

  // Configuration registers
  logic [31:0] min_chunk_q;
  logic [4:0]  align_log2_q;
  logic [5:0]  frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_chunk_q  <= DefMinChunk;
      align_log2_q <= DefAlignLog2;
      frames_q     <= DefFrames;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_CHUNK:  min_chunk_q  <= cfg_wdata_i;
        CFG_ALIGN_LOG2: align_log2_q <= cfg_wdata_i[4:0];
        CFG_FRAMES:     frames_q     <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Allocator state
  logic [31:0]     frame_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] lu_q;
  logic            lu_valid_q;
  logic [31:0]     size_q;
  logic [IdxW-1:0] cur_q;
  logic            on_lu_q;
  logic            skip_q;

  // Chunk table
  logic [31:0] cap_mem   [MaxChunks];
  logic [31:0] used_mem  [MaxChunks];
  logic [31:0] frame_mem [MaxChunks];
  logic [31:0] rd_cap_q, rd_used_q, rd_frame_q;

  // Scan order: last-used entry first, then table order without it
  logic            lu_ok;
  logic [IdxW-1:0] first_addr;
  logic [CntW:0]   nxt0, nxt;
  logic            more;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  always_comb begin
    lu_ok      = lu_valid_q && (CntW'(lu_q) < count_q);
    first_addr = lu_ok ? lu_q : '0;
    nxt0       = on_lu_q ? '0 : ((CntW + 1)'(cur_q) + (CntW + 1)'(1));
    nxt        = (skip_q && (nxt0 == (CntW + 1)'(lu_q))) ? nxt0 + (CntW + 1)'(1) : nxt0;
    more       = nxt < (CntW + 1)'(count_q);
    rd_en      = cmd_i.start || cmd_i.step;
    rd_addr    = cmd_i.start ? first_addr : nxt[IdxW-1:0];
  end

  // Recycle check and aligned bump on the entry just read
  logic [5:0]  frames_eff;
  logic [31:0] age_limit;
  logic        recycle;
  logic [32:0] mask;
  logic [31:0] used_eff;
  logic [32:0] off;
  logic [33:0] end_sum;
  logic        fit;

  always_comb begin
    frames_eff = (frames_q == 6'd0) ? DefFrames : frames_q;
    age_limit  = frame_q - 32'(frames_eff);
    recycle    = (frame_q >= 32'(frames_eff)) && (rd_frame_q <= age_limit);
    mask       = (33'd1 << align_log2_q) - 33'd1;
    used_eff   = recycle ? 32'd0 : rd_used_q;
    off        = ({1'b0, used_eff} + mask) & ~mask;
    end_sum    = {1'b0, off} + 34'(size_q);
    fit        = end_sum <= 34'(rd_cap_q);
  end

  // Capacity of a new chunk
  logic [31:0] min_eff, cap_base;
  logic [32:0] cap_sum, cap_al;
  logic [31:0] new_cap;

  always_comb begin
    min_eff  = (min_chunk_q == 32'd0) ? DefMinChunk : min_chunk_q;
    cap_base = (size_q > min_eff) ? size_q : min_eff;
    cap_sum  = {1'b0, cap_base} + mask;
    cap_al   = cap_sum & ~mask;
    new_cap  = cap_al[32] ? (32'hFFFF_FFFF & ~mask[31:0]) : cap_al[31:0];
  end

  // Table write port
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [31:0]     wr_used;

  always_comb begin
    wr_en   = (cmd_i.eval && (fit || recycle)) || cmd_i.create;
    wr_addr = cmd_i.create ? count_q[IdxW-1:0] : cur_q;
    if (cmd_i.create) begin
      wr_used = size_q;
    end else if (fit) begin
      wr_used = end_sum[31:0];
    end else begin
      wr_used = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      used_mem[wr_addr]  <= wr_used;
      frame_mem[wr_addr] <= frame_q;
    end
    if (cmd_i.create) begin
      cap_mem[wr_addr] <= new_cap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_cap_q   <= cap_mem[rd_addr];
      rd_used_q  <= used_mem[rd_addr];
      rd_frame_q <= frame_mem[rd_addr];
    end
  end

  // Scan position and request size
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      size_q <= req_size_i;
    end
    if (rd_en) begin
      cur_q <= rd_addr;
    end
    if (cmd_i.start) begin
      on_lu_q <= lu_ok;
      skip_q  <= lu_ok;
    end else if (cmd_i.step) begin
      on_lu_q <= 1'b0;
    end
  end

  // Frame counter, fill count and last-used entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q    <= '0;
      count_q    <= '0;
      lu_q       <= '0;
      lu_valid_q <= 1'b0;
    end else begin
      if (cmd_i.advance) begin
        frame_q <= frame_q + 32'd1;
      end
      if (cmd_i.hit) begin
        lu_q       <= cur_q;
        lu_valid_q <= 1'b1;
      end
      if (cmd_i.create) begin
        count_q    <= count_q + CntW'(1);
        lu_q       <= count_q[IdxW-1:0];
        lu_valid_q <= 1'b1;
      end
    end
  end

  // Result staging
  logic        res_status_q, res_created_q;
  logic [3:0]  res_index_q;
  logic [31:0] res_offset_q, res_cap_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit) begin
      res_status_q  <= 1'b0;
      res_index_q   <= 4'(cur_q);
      res_offset_q  <= off[31:0];
      res_created_q <= 1'b0;
      res_cap_q     <= rd_cap_q;
    end else if (cmd_i.create) begin
      res_status_q  <= 1'b0;
      res_index_q   <= 4'(count_q);
      res_offset_q  <= 32'd0;
      res_created_q <= 1'b1;
      res_cap_q     <= new_cap;
    end else if (cmd_i.advance || cmd_i.fail) begin
      res_status_q  <= cmd_i.fail;
      res_index_q   <= 4'd0;
      res_offset_q  <= 32'd0;
      res_created_q <= 1'b0;
      res_cap_q     <= 32'd0;
    end
  end

  // Output register
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_o   <= res_status_q;
      out_index_o    <= res_index_q;
      out_byte_off_o <= res_offset_q;
      out_created_o  <= res_created_q;
      out_capacity_o <= res_cap_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  always_comb begin
    status_o.start_ok = lu_ok || (count_q != '0);
    status_o.fit      = fit;
    status_o.more     = more;
    status_o.full     = count_q >= CntW'(MaxChunks);
    status_o.out_free = out_free;
  end

endmodule

// File: src/frame_recycled_chunk_allocator_top.sv
// An allocation runs from the transfer through P table probes (none while the table is
// empty, else 1 to MaxChunks, one per cycle through the read port), then a create step when
// a new chunk is recorded or the table is full, then the result step; a frame advance goes
// straight to the result step. One item at a time: a new request waits for the last result.
// Reset clears the frame counter, chunk count and last-used entry; table contents are
// only read once written, so no clearing pass is needed.
module frame_recycled_chunk_allocator_top #(
  parameter int MaxChunks = frca_pkg::MaxChunksDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [frca_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [frca_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [frca_pkg::InDataW-1:0]   s_axis_tdata_i,   // [31:0] req_size
  input  logic                           s_axis_tuser_i,   // [0] req_type
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [3:0] chunk_index, [35:4] alloc_offset, [36] chunk_created,
  // [68:37] chunk_capacity, [71:69] zero
  output logic [frca_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tuser_o    // [0] status
);
  import frca_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  logic        out_status, out_created;
  logic [3:0]  out_index;
  logic [31:0] out_byte_off, out_capacity;

  frca_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_advance_i (s_axis_tuser_i),
    .in_ready_o   (s_axis_tready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  frca_datapath #(
    .MaxChunks (MaxChunks)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_size_i     (s_axis_tdata_i[31:0]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_status_o   (out_status),
    .out_index_o    (out_index),
    .out_byte_off_o (out_byte_off),
    .out_created_o  (out_created),
    .out_capacity_o (out_capacity),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {3'b000, out_capacity, out_created, out_byte_off, out_index};
  assign m_axis_tuser_o = out_status;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import frca_pkg::*;

  localparam int MAX_CHUNKS = MaxChunksDefault;
  localparam int DIR_ROWS = 18;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DRAIN_CYCLES = 25;

  // Request kinds and result status codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        status;
    logic [3:0]  idx;
    logic [31:0] offset;
    logic        created;
    logic [31:0] capacity;
  } grant_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] size;
    logic        fixed;   // expectation typed in below
    grant_t      grant;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_wdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i = '0;   // [31:0] req_size
  logic                  s_axis_tuser_i = 1'b0; // [0] req_type
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // [3:0] chunk_index, [35:4] alloc_offset, [36] chunk_created, [68:37] chunk_capacity
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic                  m_axis_tuser_o;        // [0] status

  frame_recycled_chunk_allocator_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the allocator state and registers
  logic [31:0] min_chunk_cfg = DefMinChunk;
  logic [4:0]  align_cfg = DefAlignLog2;
  logic [5:0]  frames_cfg = DefFrames;
  logic [31:0] frame_cnt = '0;
  int          chunk_cnt = 0;
  logic [3:0]  last_idx = '0;
  bit          last_valid = 1'b0;
  logic [31:0] chunk_cap [MAX_CHUNKS];
  logic [31:0] chunk_used [MAX_CHUNKS];
  logic [31:0] chunk_frame [MAX_CHUNKS];

  grant_t grant_q [$];
  int     fail_cnt = 0;
  int     burst_left = 0;
  bit     gaps_on = 1'b1;
  int     rx_mode = 1;
  int     rx_tick = 0;

  // Recycle an aged chunk, then try an aligned bump inside it
  function automatic bit try_bump(input int i, input logic [31:0] size,
                                  input logic [63:0] mask, output logic [31:0] offset);
    logic [31:0] age;
    logic [63:0] off;
    age = (frames_cfg == 0) ? 32'(DefFrames) : 32'(frames_cfg);
    offset = '0;
    if (frame_cnt >= age && chunk_frame[i] <= frame_cnt - age) begin
      chunk_used[i] = '0;
      chunk_frame[i] = frame_cnt;
    end
    off = ({32'd0, chunk_used[i]} + mask) & ~mask;
    if (off + {32'd0, size} > {32'd0, chunk_cap[i]}) return 1'b0;
    offset = off[31:0];
    chunk_used[i] = off[31:0] + size;
    chunk_frame[i] = frame_cnt;
    return 1'b1;
  endfunction

  // Expected grant for one request; updates the shadow state
  function automatic grant_t predict_grant(input logic kind, input logic [31:0] size);
    grant_t      g;
    logic [63:0] mask;
    logic [63:0] cap;
    logic [31:0] minc;
    logic [31:0] off;
    int          sel;
    bit          hit;
    g = '0;
    off = '0;
    sel = 0;
    hit = 1'b0;
    if (kind == REQ_ADVANCE) begin
      frame_cnt = frame_cnt + 1;
      return g;
    end
    mask = (64'd1 << align_cfg) - 1;
    if (last_valid && int'(last_idx) < chunk_cnt) begin
      hit = try_bump(int'(last_idx), size, mask, off);
      sel = int'(last_idx);
    end
    for (int i = 0; !hit && i < chunk_cnt; i++) begin
      hit = try_bump(i, size, mask, off);
      sel = i;
    end
    if (!hit) begin
      if (chunk_cnt >= MAX_CHUNKS) begin
        g.status = STATUS_FULL;
        return g;
      end
      minc = (min_chunk_cfg == 0) ? DefMinChunk : min_chunk_cfg;
      cap = {32'd0, (size > minc) ? size : minc};
      cap = (cap + mask) & ~mask;
      if (cap > 64'hFFFF_FFFF) cap = 64'hFFFF_FFFF & ~mask;
      sel = chunk_cnt;
      chunk_cap[sel] = cap[31:0];
      chunk_used[sel] = size;
      chunk_frame[sel] = frame_cnt;
      chunk_cnt++;
      off = '0;
      g.created = 1'b1;
    end
    last_idx = sel[3:0];
    last_valid = 1'b1;
    g.status = STATUS_OK;
    g.idx = sel[3:0];
    g.offset = off;
    g.capacity = chunk_cap[sel];
    return g;
  endfunction

  // Register write, only issued while the block is idle
  task automatic write_reg(input cfg_index_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_MIN_CHUNK:  min_chunk_cfg = value;
      CFG_ALIGN_LOG2: align_cfg = value[4:0];
      CFG_FRAMES:     frames_cfg = value[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One request transfer, sent in bursts with random gaps between them while gaps are on
  task automatic push_request(input logic kind, input logic [31:0] size,
                              input logic fixed, input grant_t fixed_grant);
    int     gap;
    grant_t g;
    gap = 0;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) gap = $urandom_range(1, 7);
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= size;
    s_axis_tuser_i <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    g = predict_grant(kind, size);
    grant_q.push_back(fixed ? fixed_grant : g);
  endtask

  // Let every pending grant come back before touching the registers
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (MAX_CHUNKS + 4) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready_i <= ((rx_tick % 17) >= 9);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (grant_q.size() == 0) begin
        $error("result transfer with no request pending");
        fail_cnt++;
      end else begin
        want = grant_q.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser_o));
        check_field("chunk_index", 32'(want.idx), 32'(m_axis_tdata_o[3:0]));
        check_field("alloc_offset", want.offset, m_axis_tdata_o[35:4]);
        check_field("chunk_created", 32'(want.created), 32'(m_axis_tdata_o[36]));
        check_field("chunk_capacity", want.capacity, m_axis_tdata_o[68:37]);
      end
    end
  end

  // Directed rows, run at the reset register values
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_ALLOC,   32'h0000_0000, 1'b1, '{STATUS_OK, 4'd0, 32'd0, 1'b1, 32'd2097152}},
    '{REQ_ALLOC,   32'h0000_0001, 1'b0, '0},
    '{REQ_ALLOC,   32'h0000_0001, 1'b0, '0},
    '{REQ_ADVANCE, 32'h0000_0000, 1'b1, '0},
    // oversize: capacity saturates below 2^32
    '{REQ_ALLOC,   32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 4'd1, 32'd0, 1'b1, 32'hFFFF_FF00}},
    // early frame: no recycle while the frame count is below the window
    '{REQ_ALLOC,   32'h0020_0000, 1'b0, '0},
    '{REQ_ALLOC,   32'h0000_0000, 1'b0, '0},
    '{REQ_ADVANCE, 32'hFFFF_FFFF, 1'b1, '0},
    '{REQ_ADVANCE, 32'h0000_0000, 1'b1, '0},
    '{REQ_ALLOC,   32'h0000_0064, 1'b0, '0},
    '{REQ_ALLOC,   32'hFFFF_FF00, 1'b0, '0},
    '{REQ_ALLOC,   32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_ALLOC,   32'h5555_5555, 1'b0, '0},
    '{REQ_ADVANCE, 32'h0000_0000, 1'b1, '0},
    '{REQ_ADVANCE, 32'h0000_0000, 1'b1, '0},
    '{REQ_ADVANCE, 32'h0000_0000, 1'b1, '0},
    '{REQ_ALLOC,   32'h0000_0100, 1'b0, '0},
    '{REQ_ALLOC,   32'h001F_FFFF, 1'b0, '0}
  };

  // Register settings per random phase: min chunk, align, frames in flight
  logic [31:0] phase_min [PHASES] = '{32'd4096, 32'd2097152, 32'd0, 32'd300,
                                      32'hFFFF_FFFF, 32'd65536, 32'd1, 32'd12345, 32'd1};
  logic [31:0] phase_align [PHASES] = '{32'd4, 32'd8, 32'd8, 32'd2, 32'd16, 32'd31,
                                        32'd0, 32'd12, 32'd0};
  logic [31:0] phase_frames [PHASES] = '{32'd2, 32'd3, 32'd0, 32'd5, 32'd32, 32'd63,
                                         32'd1, 32'd4, 32'd1};

  // Stimulus
  initial begin
    logic [31:0] size;
    logic [31:0] minc;
    int          pick;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      push_request(dir_rows[r].kind, dir_rows[r].size, dir_rows[r].fixed,
                   dir_rows[r].grant);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_MIN_CHUNK, phase_min[p]);
      write_reg(CFG_ALIGN_LOG2, phase_align[p]);
      write_reg(CFG_FRAMES, phase_frames[p]);
      gaps_on = (p % 3 != 0);
      rx_mode = (p + 1) % 3;
      minc = (min_chunk_cfg == 0) ? DefMinChunk : min_chunk_cfg;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          push_request(REQ_ADVANCE, $urandom, 1'b0, '0);
        end else begin
          if (pick < 60)      size = $urandom_range(0, 600);
          else if (pick < 75) size = $urandom_range(0, 32'h0010_0000);
          else if (pick < 85) size = $urandom_range(0, minc);
          else if (pick < 95) size = $urandom;
          else                size = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
          push_request(REQ_ALLOC, size, 1'b0, '0);
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("frame_recycled_chunk_allocator_top verification clean");
    end else begin
      $display("frame_recycled_chunk_allocator_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("frame_recycled_chunk_allocator_top verification failed");
    $finish;
  end

endmodule
